FILE: design/assert_macros.svh
// Assertion macros used by the selector's back end.
// Depends on nothing; included by lbes_back, the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion label failed");

// The consequent must hold in the cycle after the antecedent.
`define LBES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion label failed");

`endif

FILE: design/lbes_pkg.sv
// Shared types, codes and constants of the endpoint selector.
// Depends on nothing; imported by every module of the block.
package lbes_pkg;

  localparam int ENDPOINTS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int DIV_W           = 64;

  localparam logic [63:0] DEFAULT_TIMEOUT_NS = 64'd60000000000;
  localparam logic [4:0]  COUNT_RESET        = 5'd16;

  // Selection modes as held in the mode register.
  localparam logic [2:0] MODE_RR      = 3'd0;
  localparam logic [2:0] MODE_HASH    = 3'd1;
  localparam logic [2:0] MODE_TUNNEL  = 3'd2;
  localparam logic [2:0] MODE_PERSIST = 3'd3;
  localparam logic [2:0] MODE_LEAST   = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd1;
  localparam logic [2:0] REG_MASK    = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MIX     = 3'd4;

  // Operation decided by the front end for each beat.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RELEASE,
    OP_RR,
    OP_HASH,
    OP_PERSIST,
    OP_LEAST
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] hash;
    logic [31:0] src;
    logic [63:0] now;
    logic [3:0]  rel;
  } item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  count;
    logic [15:0] inactive;
    logic [63:0] timeout;
    logic        mix;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EPOCH,
    ST_MOD,
    ST_RR_SCAN,
    ST_LC_SCAN,
    ST_LC_BUMP
  } state_t;

endpackage

FILE: design/lb_endpoint_selector.sv
// Endpoint selector: release and empty selects give the result beat from idle,
// round robin scans from its hint, least connection scans the lower half of the
// endpoints then bumps a counter, hash modes run one division, persistent an epoch
// division then a modulo one (a second on a retry, none with a zero endpoint count).
// Items run one at a time. Reset is synchronous, active low, and clears configuration
// and control state, not working or queue data. Top level: configuration registers
// and channel wiring. Depends on lbes_pkg, lbes_front and lbes_back.
module lb_endpoint_selector
  import lbes_pkg::*;
#(
  parameter int ENDPOINTS   = ENDPOINTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // tdata: flow_hash, tunnel_hash, src_ipv4, now_ns, release_index, pad
  input  logic [167:0] in_tdata,
  // tuser: cmd, is_gtp
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: endpoint_index, pad
  output logic [7:0]   out_tdata,
  // tuser: endpoint_valid
  output logic         out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [2:0]  mode_r;
  logic [4:0]  count_r;
  logic [15:0] mask_r;
  logic [63:0] timeout_r;
  logic        mix_r;
  logic [2:0]  reg_idx;
  logic        cfg_we, tmo_load;
  cfg_t        cfg;
  logic        item_valid, item_ready;
  item_t       item;
  logic        res_ok;
  logic [3:0]  res_idx;

  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RR;
      count_r   <= COUNT_RESET;
      mask_r    <= '0;
      timeout_r <= DEFAULT_TIMEOUT_NS;
      mix_r     <= 1'b0;
    end else begin
      if (tmo_load) timeout_r <= DEFAULT_TIMEOUT_NS;
      if (cfg_we) begin
        unique case (reg_idx)
          REG_MODE:    mode_r    <= cfg_pwdata[2:0];
          REG_COUNT:   count_r   <= cfg_pwdata[4:0];
          REG_MASK:    mask_r    <= cfg_pwdata[15:0];
          REG_TIMEOUT: timeout_r <= cfg_pwdata;
          REG_MIX:     mix_r     <= cfg_pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_MODE:    cfg_prdata = {61'b0, mode_r};
      REG_COUNT:   cfg_prdata = {59'b0, count_r};
      REG_MASK:    cfg_prdata = {48'b0, mask_r};
      REG_TIMEOUT: cfg_prdata = timeout_r;
      REG_MIX:     cfg_prdata = {63'b0, mix_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg = '{mode: mode_r, count: count_r, inactive: mask_r,
                 timeout: timeout_r, mix: mix_r};

  lbes_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .cmd           (in_tuser[0]),
    .flow_hash     (in_tdata[31:0]),
    .tunnel_hash   (in_tdata[63:32]),
    .is_gtp        (in_tuser[1]),
    .src_ipv4      (in_tdata[95:64]),
    .now_ns        (in_tdata[159:96]),
    .release_index (in_tdata[163:160]),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  lbes_back #(
    .ENDPOINTS   (ENDPOINTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tmo_load   (tmo_load),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_ok     (res_ok),
    .res_idx    (res_idx)
  );

  assign out_tdata = {4'b0, res_idx};
  assign out_tuser = res_ok;

endmodule

FILE: design/lbes_front.sv
// Front end: accepts input beats, classifies them into operations and
// queues them in a two-entry buffer. Depends on lbes_pkg.
module lbes_front
  import lbes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [2:0]   mode,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         cmd,
  input  logic [31:0]  flow_hash,
  input  logic [31:0]  tunnel_hash,
  input  logic         is_gtp,
  input  logic [31:0]  src_ipv4,
  input  logic [63:0]  now_ns,
  input  logic [3:0]   release_index,
  output logic         item_valid,
  input  logic         item_ready,
  output item_t        item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push, pop;

  // Classify the beat by command and mode.
  always_comb begin
    cls      = '0;
    cls.src  = src_ipv4;
    cls.now  = now_ns;
    cls.rel  = release_index;
    cls.hash = flow_hash;
    if (cmd) begin
      cls.op = OP_RELEASE;
    end else begin
      unique case (mode)
        MODE_RR:      cls.op = OP_RR;
        MODE_HASH:    cls.op = OP_HASH;
        MODE_TUNNEL: begin
          cls.hash = tunnel_hash;
          cls.op   = is_gtp ? OP_HASH : OP_NONE;
        end
        MODE_PERSIST: cls.op = OP_PERSIST;
        MODE_LEAST:   cls.op = OP_LEAST;
        default:      cls.op = OP_NONE;
      endcase
    end
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = mem_r[rd_ptr_r];
  assign push       = in_valid & in_ready;
  assign pop        = item_valid & item_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/lbes_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lbes_pkg for the operand width.
module lbes_div
  import lbes_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dsr_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   sh, diff;
  logic             ge;

  // One shift-and-subtract step.
  always_comb begin
    sh      = {rem_r, quo_r[DIV_W-1]};
    diff    = sh - {1'b0, dsr_r};
    ge      = ~diff[DIV_W];
    rem_nxt = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Step counter and status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: design/lbes_back.sv
// Back end: sequencer that carries out one operation at a time, holds the
// selection state and session counters, and registers the result beat.
// Depends on lbes_pkg, lbes_div and assert_macros.svh.
`include "assert_macros.svh"
module lbes_back
  import lbes_pkg::*;
#(
  parameter int ENDPOINTS   = ENDPOINTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  output logic       tmo_load,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       res_ok,
  output logic [3:0] res_idx
);

  localparam int IW   = $clog2(ENDPOINTS);
  localparam int HALF = ENDPOINTS / 2;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [3:0] out4(input logic [IW-1:0] v);
    logic [IW+3:0] w;
    w = {4'b0, v};
    return w[3:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic [IW-1:0]          i_r, i_nxt, n_r, n_nxt, best_r, best_nxt;
  logic [COUNT_WIDTH-1:0] bestcnt_r, bestcnt_nxt;
  logic                   found_r, found_nxt, second_r, second_nxt, persist_r, persist_nxt;
  logic [31:0]            a_r, a_nxt;
  logic [7:0]             mix_r, mix_nxt;
  logic [3:0]             rr_next_r, rr_next_nxt;
  logic [63:0]            epoch_base_r, epoch_base_nxt, last_seen_r, last_seen_nxt;
  logic                   lc_used_r, lc_used_nxt;
  logic                   res_valid_r, res_valid_nxt, res_ok_r, res_ok_nxt;
  logic [3:0]             res_idx_r, res_idx_nxt;
  logic [COUNT_WIDTH-1:0] session_r [ENDPOINTS];

  logic                   sess_we;
  logic [IW-1:0]          sess_wa;
  logic [COUNT_WIDTH-1:0] sess_wd;

  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_r;

  logic [ENDPOINTS-1:0] inact;
  logic [IW-1:0]        fb_idx, rr_mod, r_idx, rel_idx, i_inc;
  logic                 fb_any;
  logic [3:0]           rr_t;
  logic [IW+3:0]        rr_ext;
  logic [6:0]           r7, rel7;
  logic [63:0]          tmo_eff, base_new;
  logic [7:0]           mix_now;
  logic                 take;

  // Inactive flag per endpoint; endpoints above the mask are always active.
  for (genvar g = 0; g < ENDPOINTS; g++) begin : g_inact
    if (g < 16) begin : g_lo
      assign inact[g] = cfg.inactive[g];
    end else begin : g_hi
      assign inact[g] = 1'b0;
    end
  end

  // Lowest-numbered active endpoint.
  always_comb begin
    fb_any = 1'b0;
    fb_idx = '0;
    for (int k = ENDPOINTS - 1; k >= 0; k--) begin
      if (!inact[k]) begin
        fb_any = 1'b1;
        fb_idx = IW'(k);
      end
    end
  end

  // Round-robin hint reduced into the endpoint range.
  always_comb begin
    rr_t = rr_next_r;
    for (int k = 0; k < 8; k++) begin
      if (32'(rr_t) >= ENDPOINTS) rr_t = rr_t - 4'(ENDPOINTS);
    end
    rr_ext = {{IW{1'b0}}, rr_t};
    rr_mod = rr_ext[IW-1:0];
  end

  assign r7      = div_r[6:0];
  assign r_idx   = r7[IW-1:0];
  assign rel7    = {3'b0, item.rel};
  assign rel_idx = rel7[IW-1:0];
  assign i_inc   = (i_r == IW'(ENDPOINTS - 1)) ? '0 : i_r + IW'(1);
  assign tmo_eff = (cfg.timeout == 64'd0) ? DEFAULT_TIMEOUT_NS : cfg.timeout;
  assign mix_now = cfg.mix ? div_q[7:0] : 8'd0;
  assign take    = !inact[i_r] && (!found_r || bestcnt_r > session_r[i_r]);
  assign base_new = ((epoch_base_r == 64'd0) || ((item.now - last_seen_r) > cfg.timeout))
                  ? item.now : epoch_base_r;

  // Next state and outputs of the sequencer.
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    n_nxt          = n_r;
    best_nxt       = best_r;
    bestcnt_nxt    = bestcnt_r;
    found_nxt      = found_r;
    second_nxt     = second_r;
    persist_nxt    = persist_r;
    a_nxt          = a_r;
    mix_nxt        = mix_r;
    rr_next_nxt    = rr_next_r;
    epoch_base_nxt = epoch_base_r;
    last_seen_nxt  = last_seen_r;
    lc_used_nxt    = lc_used_r;
    res_valid_nxt  = res_valid_r & ~res_ready;
    res_ok_nxt     = res_ok_r;
    res_idx_nxt    = res_idx_r;
    item_ready     = (state_r == ST_IDLE) && !res_valid_r;
    tmo_load       = 1'b0;
    div_start      = 1'b0;
    div_a          = '0;
    div_b          = {59'b0, cfg.count};
    sess_we        = 1'b0;
    sess_wa        = i_r;
    sess_wd        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid && item_ready) begin
          // Default result: nothing selected.
          res_valid_nxt = 1'b1;
          res_ok_nxt    = 1'b0;
          res_idx_nxt   = 4'd0;
          case (item.op)
            OP_RELEASE: begin
              if (lc_used_r && (item.rel < ENDPOINTS) && (session_r[rel_idx] != '0)) begin
                sess_we = 1'b1;
                sess_wa = rel_idx;
                sess_wd = session_r[rel_idx] - COUNT_WIDTH'(1);
              end
            end
            OP_RR: begin
              res_valid_nxt = 1'b0;
              i_nxt         = rr_mod;
              n_nxt         = '0;
              state_nxt     = ST_RR_SCAN;
            end
            OP_HASH: begin
              if (cfg.count != 5'd0) begin
                res_valid_nxt = 1'b0;
                div_start     = 1'b1;
                div_a         = {32'b0, item.hash};
                persist_nxt   = 1'b0;
                second_nxt    = 1'b0;
                state_nxt     = ST_MOD;
              end
            end
            OP_PERSIST: begin
              res_valid_nxt  = 1'b0;
              epoch_base_nxt = base_new;
              last_seen_nxt  = item.now;
              tmo_load       = (cfg.timeout == 64'd0);
              a_nxt          = item.src;
              div_start      = 1'b1;
              div_a          = base_new;
              div_b          = tmo_eff;
              state_nxt      = ST_EPOCH;
            end
            OP_LEAST: begin
              res_valid_nxt = 1'b0;
              lc_used_nxt   = 1'b1;
              i_nxt         = '0;
              found_nxt     = 1'b0;
              state_nxt     = ST_LC_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_EPOCH: begin
        if (div_done) begin
          mix_nxt = mix_now;
          if (cfg.count == 5'd0) begin
            res_valid_nxt = 1'b1;
            res_ok_nxt    = 1'b0;
            res_idx_nxt   = 4'd0;
            state_nxt     = ST_IDLE;
          end else begin
            div_start   = 1'b1;
            div_a       = {56'b0, a_r[7:0] ^ a_r[31:24] ^ mix_now};
            persist_nxt = 1'b1;
            second_nxt  = 1'b0;
            state_nxt   = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        if (div_done) begin
          state_nxt     = ST_IDLE;
          res_valid_nxt = 1'b1;
          res_ok_nxt    = 1'b0;
          res_idx_nxt   = 4'd0;
          if (32'(r7) < ENDPOINTS) begin
            if (!inact[r_idx]) begin
              res_ok_nxt  = 1'b1;
              res_idx_nxt = out4(r_idx);
            end else if (persist_r && !second_r) begin
              // Persistent mode tries the middle address bytes next.
              res_valid_nxt = 1'b0;
              div_start     = 1'b1;
              div_a         = {56'b0, a_r[15:8] ^ a_r[23:16] ^ mix_r};
              second_nxt    = 1'b1;
              state_nxt     = ST_MOD;
            end else begin
              res_ok_nxt  = 1'b1;
              res_idx_nxt = out4(fb_any ? fb_idx : r_idx);
            end
          end
        end
      end

      ST_RR_SCAN: begin
        if (!inact[i_r]) begin
          rr_next_nxt   = out4(i_inc);
          res_valid_nxt = 1'b1;
          res_ok_nxt    = 1'b1;
          res_idx_nxt   = out4(i_r);
          state_nxt     = ST_IDLE;
        end else if (n_r == IW'(ENDPOINTS - 1)) begin
          res_valid_nxt = 1'b1;
          res_ok_nxt    = 1'b0;
          res_idx_nxt   = 4'd0;
          state_nxt     = ST_IDLE;
        end else begin
          i_nxt = i_inc;
          n_nxt = n_r + IW'(1);
        end
      end

      ST_LC_SCAN: begin
        if (take) begin
          best_nxt    = i_r;
          bestcnt_nxt = session_r[i_r];
          found_nxt   = 1'b1;
        end
        if (i_r == IW'(HALF - 1)) begin
          if (take || found_r) begin
            state_nxt = ST_LC_BUMP;
          end else begin
            res_valid_nxt = 1'b1;
            res_ok_nxt    = 1'b0;
            res_idx_nxt   = 4'd0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end

      ST_LC_BUMP: begin
        if (session_r[best_r] != CMAX) begin
          sess_we = 1'b1;
          sess_wa = best_r;
          sess_wd = session_r[best_r] + COUNT_WIDTH'(1);
        end
        res_valid_nxt = 1'b1;
        res_ok_nxt    = 1'b1;
        res_idx_nxt   = out4(best_r);
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and selection state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_next_r    <= '0;
      epoch_base_r <= '0;
      last_seen_r  <= '0;
      lc_used_r    <= 1'b0;
      res_valid_r  <= 1'b0;
      for (int k = 0; k < ENDPOINTS; k++) session_r[k] <= '0;
    end else begin
      rr_next_r    <= rr_next_nxt;
      epoch_base_r <= epoch_base_nxt;
      last_seen_r  <= last_seen_nxt;
      lc_used_r    <= lc_used_nxt;
      res_valid_r  <= res_valid_nxt;
      if (sess_we) session_r[sess_wa] <= sess_wd;
    end
  end

  // Working registers of the current operation.
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    n_r       <= n_nxt;
    best_r    <= best_nxt;
    bestcnt_r <= bestcnt_nxt;
    found_r   <= found_nxt;
    second_r  <= second_nxt;
    persist_r <= persist_nxt;
    a_r       <= a_nxt;
    mix_r     <= mix_nxt;
    res_ok_r  <= res_ok_nxt;
    res_idx_r <= res_idx_nxt;
  end

  lbes_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign res_valid = res_valid_r;
  assign res_ok    = res_ok_r;
  assign res_idx   = res_idx_r;

  // A new division never starts over one in progress.
  `LBES_ASSERT_SAME(a_div_free, clk, rst_n, div_start, !div_busy)
  // An empty selection always reports endpoint zero.
  `LBES_ASSERT_SAME(a_empty_zero, clk, rst_n, res_valid_r && !res_ok_r, res_idx_r == 4'd0)
  // A beat taken from the queue always moves the sequencer out of idle or registers a result.
  `LBES_ASSERT_NEXT(a_pop_idle, clk, rst_n, item_valid && item_ready,
                    (state_r != ST_IDLE) || res_valid_r)
  // Division results only arrive while waiting for them.
  `LBES_ASSERT_SAME(a_done_wait, clk, rst_n, div_done,
                    (state_r == ST_EPOCH) || (state_r == ST_MOD))

endmodule
